[rtl/core/hsc_pkg.sv]
package hsc_pkg;

  localparam int unsigned POS_W = 20;

  // parity check masks
  localparam logic [7:0] MASK_P3 = 8'hAA;
  localparam logic [7:0] MASK_P2 = 8'h66;
  localparam logic [7:0] MASK_P1 = 8'h1E;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ODD     = 2'd1,
    ST_TOOLONG = 2'd2,
    ST_UNCORR  = 2'd3
  } hsc_status_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    hsc_status_t      code;
    logic             is_status;
    logic [7:0]       data;
    logic             last;
  } hsc_item_t;

  typedef struct packed {
    logic      has_second;
    hsc_item_t item1;
    hsc_item_t item0;
  } hsc_entry_t;

  typedef struct packed {
    logic       valid;
    hsc_entry_t entry;
  } hsc_push_t;

  function automatic logic [7:0] hsc_codeword(input logic [3:0] nib);
    logic [7:0] cw;
    unique case (nib)
      4'h0: cw = 8'h00;
      4'h1: cw = 8'hD2;
      4'h2: cw = 8'h55;
      4'h3: cw = 8'h87;
      4'h4: cw = 8'h99;
      4'h5: cw = 8'h4B;
      4'h6: cw = 8'hCC;
      4'h7: cw = 8'h1E;
      4'h8: cw = 8'hE1;
      4'h9: cw = 8'h33;
      4'hA: cw = 8'hB4;
      4'hB: cw = 8'h66;
      4'hC: cw = 8'h78;
      4'hD: cw = 8'hAA;
      4'hE: cw = 8'h2D;
      default: cw = 8'hFF;
    endcase
    return cw;
  endfunction

  // Returns {uncorrectable, corrected nibble}.
  function automatic logic [4:0] hsc_decode(input logic [7:0] w);
    logic [3:0] d;
    logic [3:0] syn;
    logic [4:0] res;
    d   = {w[5], w[3], w[2], w[1]};
    syn = {^(w & MASK_P3), ^(w & MASK_P2), ^(w & MASK_P1), ^w};
    unique case (syn)
      4'h0, 4'h1, 4'h3, 4'h5, 4'h9: res = {1'b0, d};
      4'hF: res = {1'b0, d ^ 4'h1};
      4'h7: res = {1'b0, d ^ 4'h2};
      4'hB: res = {1'b0, d ^ 4'h4};
      4'hD: res = {1'b0, d ^ 4'h8};
      default: res = {1'b1, d};
    endcase
    return res;
  endfunction

endpackage

[rtl/core/hamming_8_4_stream_codec_unit.sv]
// Channel  Ports                         Payload
// -------  ----------------------------  --------------------------------------------
// input    in_tvalid/in_tready/in_tdata  in_byte; in_tlast = last item of block
// output   out_tvalid/out_tready/...     out_byte, status_code, error_position;
//                                        out_tuser = is_status, out_tlast = last result
// config   cfg_wr_en/cfg_wr_data         decode_mode, written when cfg_wr_en is high
//
// Encode: two codewords per transaction, which leave one at a time through the one
// output register. Decode: a data byte and a status can both leave for one input.
// Each result passes through the queue and then the output register.
// Reset clears stream state, decode_mode, the queue and the output register.
// A stall at out_tready fills the two-entry queue, then drops in_tready.
module hamming_8_4_stream_codec_unit import hsc_pkg::*; #(
  parameter int unsigned LEN_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [9:8] status_code,
                                  // [29:10] error_position, [31:30] zero
  output logic        out_tuser,  // [0] is_status
  output logic        out_tlast
);

  hsc_push_t  push;
  hsc_entry_t head;
  hsc_item_t  item;
  logic       full;
  logic       head_valid;
  logic       pop;
  logic       accept;

  assign in_tready = ~full;
  assign accept    = in_tvalid & ~full;

  // Classify each accepted transaction and update the block state.
  hsc_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .push       (push)
  );

  // Decouple the front from output stalls.
  hsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  // Emit one or two results per queue entry.
  hsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (item)
  );

  assign out_tdata = {2'b00, item.pos, item.code, item.data};
  assign out_tuser = item.is_status;
  assign out_tlast = item.last;

endmodule

[rtl/core/hsc_front.sv]
module hsc_front import hsc_pkg::*; #(
  parameter int unsigned LEN_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output hsc_push_t  push
);

  logic                decode_mode_r;
  logic                second_half_r, second_half_nxt;
  logic [3:0]          held_r, held_nxt;
  logic [LEN_BITS:0]   idx_r, idx_nxt;
  logic                err_r, err_nxt;

  logic [4:0]          dec;
  logic                data_out;
  hsc_item_t           data_item;
  hsc_item_t           stat_item;
  hsc_push_t           push_c;

  assign dec = hsc_decode(in_byte);

  always_comb begin
    second_half_nxt = second_half_r;
    held_nxt        = held_r;
    idx_nxt         = idx_r;
    err_nxt         = err_r;
    data_out        = 1'b0;
    data_item       = '0;
    stat_item       = '0;
    push_c          = '0;

    if (!decode_mode_r) begin
      push_c.valid                  = 1'b1;
      push_c.entry.has_second       = 1'b1;
      push_c.entry.item0.data       = hsc_codeword(in_byte[3:0]);
      push_c.entry.item1.data       = hsc_codeword(in_byte[7:4]);
      push_c.entry.item1.last       = 1'b1;
    end else begin
      if (!err_r) begin
        if (dec[4]) begin
          err_nxt = 1'b1;
        end else begin
          if (second_half_r) begin
            data_out        = 1'b1;
            data_item.data  = {dec[3:0], held_r};
            data_item.last  = ~in_last;
            second_half_nxt = 1'b0;
            held_nxt        = 4'h0;
          end else begin
            held_nxt        = dec[3:0];
            second_half_nxt = 1'b1;
          end
          if (!idx_r[LEN_BITS]) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      stat_item.is_status = 1'b1;
      stat_item.last      = 1'b1;
      priority if (err_nxt) begin
        if (idx_nxt[LEN_BITS]) begin
          stat_item.code = ST_TOOLONG;
        end else begin
          stat_item.code = ST_UNCORR;
          stat_item.pos  = POS_W'(idx_nxt[LEN_BITS-1:0]);
        end
      end else if (second_half_nxt) begin
        stat_item.code = ST_ODD;
      end else if (idx_nxt[LEN_BITS]) begin
        stat_item.code = ST_TOOLONG;
      end else begin
        stat_item.code = ST_OK;
      end

      // Pack the data byte first, then the status at block end.
      push_c.valid = data_out | in_last;
      if (data_out) begin
        push_c.entry.item0      = data_item;
        push_c.entry.item1      = stat_item;
        push_c.entry.has_second = in_last;
      end else begin
        push_c.entry.item0 = stat_item;
      end
    end

    if (in_last) begin
      second_half_nxt = 1'b0;
      held_nxt        = 4'h0;
      idx_nxt         = '0;
      err_nxt         = 1'b0;
    end

    push_c.valid = push_c.valid & accept;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      second_half_r <= 1'b0;
      held_r        <= 4'h0;
      idx_r         <= '0;
      err_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        decode_mode_r <= cfg_wr_data;
      end
      if (accept) begin
        second_half_r <= second_half_nxt;
        held_r        <= held_nxt;
        idx_r         <= idx_nxt;
        err_r         <= err_nxt;
      end
    end
  end

endmodule

[rtl/core/hsc_queue.sv]
module hsc_queue import hsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hsc_push_t  push,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output hsc_entry_t head
);

  hsc_entry_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push.valid & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/core/hsc_back.sv]
module hsc_back import hsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  hsc_entry_t head,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output hsc_item_t  out_item
);

  logic      sel_r;
  logic      out_valid_r;
  hsc_item_t out_item_r;
  logic      load;

  assign load      = ~out_valid_r | out_ready;
  assign pop       = load & head_valid & (sel_r | ~head.has_second);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_item_r <= sel_r ? head.item1 : head.item0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        sel_r <= ~sel_r & head.has_second;
      end
    end
  end

endmodule

[rtl/core/hsc_checker.sv]
module hsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Stalled transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output changed under stall");

  // Status always closes the results of its input.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[7:0] == 8'h00)
    else $error("status not last or carries data");

  // Data carries no status or position.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:8] == 24'h0)
    else $error("data item has status bits");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind hamming_8_4_stream_codec_unit hsc_checker u_hsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

[tb/hamming_stream_checker.sv]
module hamming_stream_checker
  import hsc_pkg::*;
#(
  parameter int unsigned LEN_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          results_due,
  output int          results_checked,
  output logic [3:0]  status_mask
);
  timeunit 1ns;
  timeprecision 1ps;

  // codeword per nibble, nibble 0 in the low byte
  localparam logic [127:0] CW_ROM = {
    8'hFF, 8'h2D, 8'hAA, 8'h78, 8'h66, 8'hB4, 8'h33, 8'hE1,
    8'h1E, 8'hCC, 8'h4B, 8'h99, 8'h87, 8'h55, 8'hD2, 8'h00
  };
  localparam logic [LEN_BITS:0] LEN_CAP = (LEN_BITS + 1)'(1) << LEN_BITS;

  typedef struct packed {
    logic [7:0]       data;
    logic             is_status;
    hsc_status_t      code;
    logic [POS_W-1:0] pos;
    logic             last;
  } codec_result_t;

  codec_result_t   codec_results_due[$];

  logic            decode_mode;
  logic            nibble_held;
  logic [3:0]      low_nibble;
  logic [LEN_BITS:0] word_count;
  logic            block_failed;

  // {uncorrectable, nibble} after single-error correction
  function automatic logic [4:0] correct_word(input logic [7:0] w);
    logic [3:0] nib;
    logic [2:0] chk;
    nib = {w[5], w[3], w[2], w[1]};
    chk = {^(w & MASK_P3), ^(w & MASK_P2), ^(w & MASK_P1)};
    if (!(^w)) begin
      return {chk != 3'b000, nib};
    end
    case (chk)
      3'b111: nib = nib ^ 4'h1;
      3'b011: nib = nib ^ 4'h2;
      3'b101: nib = nib ^ 4'h4;
      3'b110: nib = nib ^ 4'h8;
      default: ;
    endcase
    return {1'b0, nib};
  endfunction

  task automatic add_result(input logic [7:0] data, input logic st, input hsc_status_t code,
                            input logic [POS_W-1:0] pos, input logic last);
    codec_result_t r;
    r.data      = data;
    r.is_status = st;
    r.code      = code;
    r.pos       = pos;
    r.last      = last;
    codec_results_due.push_back(r);
  endtask

  task automatic clear_block();
    nibble_held  = 1'b0;
    low_nibble   = 4'h0;
    word_count   = '0;
    block_failed = 1'b0;
  endtask

  task automatic run_codec_step(input logic [7:0] b, input logic last);
    logic [4:0] fixed;
    if (!decode_mode) begin
      add_result(CW_ROM[b[3:0]*8 +: 8], 1'b0, ST_OK, '0, 1'b0);
      add_result(CW_ROM[b[7:4]*8 +: 8], 1'b0, ST_OK, '0, 1'b1);
      if (last) clear_block();
      return;
    end
    if (!block_failed) begin
      fixed = correct_word(b);
      if (fixed[4]) begin
        block_failed = 1'b1;
      end else begin
        if (nibble_held) begin
          add_result({fixed[3:0], low_nibble}, 1'b0, ST_OK, '0, !last);
          nibble_held = 1'b0;
          low_nibble  = 4'h0;
        end else begin
          low_nibble  = fixed[3:0];
          nibble_held = 1'b1;
        end
        if (word_count < LEN_CAP) word_count = word_count + 1'b1;
      end
    end
    if (last) begin
      if (block_failed) begin
        if (word_count >= LEN_CAP) add_result(8'h00, 1'b1, ST_TOOLONG, '0, 1'b1);
        else add_result(8'h00, 1'b1, ST_UNCORR, POS_W'(word_count), 1'b1);
      end else if (nibble_held) begin
        add_result(8'h00, 1'b1, ST_ODD, '0, 1'b1);
      end else if (word_count >= LEN_CAP) begin
        add_result(8'h00, 1'b1, ST_TOOLONG, '0, 1'b1);
      end else begin
        add_result(8'h00, 1'b1, ST_OK, '0, 1'b1);
      end
      clear_block();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    codec_result_t r;
    if (codec_results_due.size() == 0) begin
      $error("result with nothing due: tdata 0x%0h tuser %b tlast %b",
             out_tdata, out_tuser, out_tlast);
      fail_count++;
      return;
    end
    r = codec_results_due.pop_front();
    check_field("out_byte", 32'(r.data), 32'(out_tdata[7:0]));
    check_field("status_code", 32'(r.code), 32'(out_tdata[9:8]));
    check_field("error_position", 32'(r.pos), 32'(out_tdata[29:10]));
    check_field("tdata pad", 32'(0), 32'(out_tdata[31:30]));
    check_field("is_status", 32'(r.is_status), 32'(out_tuser));
    check_field("last_result", 32'(r.last), 32'(out_tlast));
    if (out_tuser === 1'b1 && r.is_status) status_mask[out_tdata[9:8]] = 1'b1;
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      decode_mode = 1'b0;
      clear_block();
      codec_results_due.delete();
      fail_count      = 0;
      results_checked = 0;
      status_mask     = 4'b0000;
    end else begin
      if (cfg_wr_en) decode_mode = cfg_wr_data;
      if (in_tvalid && in_tready) run_codec_step(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    results_due = codec_results_due.size();
  end

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsc_pkg::*;

  // A short length field lets blocks reach the saturation limit in a few dozen words.
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned FULL_BLOCK   = 1 << LEN_W;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          QUIET_TAIL   = 80;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          SETTLE_CYC   = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          results_due;
  int          results_checked;
  logic [3:0]  status_mask;

  int          words_sent;
  int          stall_run;
  bit          allow_gaps;
  bit          allow_stalls;

  always #5 clk = ~clk;

  hamming_8_4_stream_codec_unit #(
    .LEN_BITS(LEN_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The checker mirrors the codec on every transaction and counts mismatches.
  hamming_stream_checker #(
    .LEN_BITS(LEN_W)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .results_checked(results_checked),
    .status_mask    (status_mask)
  );

  // Result side: hold tready low in random bursts of random length while stalls
  // are allowed, otherwise keep it high.
  initial begin
    out_tready = 1'b0;
    stall_run  = 0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) begin
        stall_run--;
        out_tready <= 1'b0;
      end else if (allow_stalls && $urandom_range(0, 7) == 0) begin
        stall_run = $urandom_range(1, 16) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Offer one word at a falling edge, possibly after a gap, and hold it until it is
  // taken. Return at the falling edge after the transaction with tvalid still high,
  // so back-to-back words never lower and raise tvalid in one step.
  task automatic send_word(input logic [7:0] b, input logic last);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Drop tvalid, wait for every due result, let ignored words flush out of the
  // pipeline, then write the mode register.
  task automatic settle_and_set_mode(input logic mode);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly clean codewords, with single flips, double flips and raw bytes mixed in.
  function automatic logic [7:0] noisy_word(input logic [3:0] nib);
    logic [7:0] w;
    int         pick;
    int         a;
    int         b;
    w    = hsc_codeword(nib);
    pick = $urandom_range(0, 19);
    a    = $urandom_range(0, 7);
    b    = (a + $urandom_range(1, 7)) % 8;
    if (pick >= 19) begin
      w = 8'($urandom);
    end else if (pick >= 17) begin
      w[a] = ~w[a];
      w[b] = ~w[b];
    end else if (pick >= 14) begin
      w[a] = ~w[a];
    end
    return w;
  endfunction

  task automatic send_decode_block(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_word(noisy_word(4'($urandom)), close && (i == len - 1));
    end
  endtask

  task automatic send_encode_block(input int len);
    for (int i = 0; i < len; i++) begin
      send_word(8'($urandom), i == len - 1);
    end
  endtask

  initial begin
    int  target;
    int  blocks;
    int  len;
    bit  mode;
    bit  close;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    allow_gaps   = 1'b0;
    allow_stalls = 1'b0;
    words_sent   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: encode extremes, then decode special cases, with stalls on.
    allow_gaps   = 1'b1;
    allow_stalls = 1'b1;
    settle_and_set_mode(1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b1);

    settle_and_set_mode(1'b1);
    // clean pair packs to one byte, status ok
    send_word(hsc_codeword(4'h3), 1'b0);
    send_word(hsc_codeword(4'hC), 1'b1);
    // single error on a data bit, then on a parity bit
    send_word(hsc_codeword(4'hF) ^ 8'h02, 1'b0);
    send_word(hsc_codeword(4'h0) ^ 8'h01, 1'b1);
    // one word alone gives odd length
    send_word(8'hFF, 1'b1);
    // double error mid-block: later words are ignored up to the last
    send_word(hsc_codeword(4'h1), 1'b0);
    send_word(hsc_codeword(4'h2) ^ 8'h81, 1'b0);
    send_word(hsc_codeword(4'h3), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    // single error on the high bit, then a clean last word
    send_word(hsc_codeword(4'h4) ^ 8'h80, 1'b0);
    send_word(8'h00, 1'b1);
    // double error on the last word itself
    send_word(hsc_codeword(4'h5) ^ 8'h0C, 1'b1);
    // leave a nibble held across a mode change; an encode last clears it
    send_word(hsc_codeword(4'h6), 1'b0);
    settle_and_set_mode(1'b0);
    send_word(8'h3C, 1'b1);

    // Random phases: pick a mode, run a few blocks, sometimes leave a decode block open.
    target = words_sent + RANDOM_ITEMS;
    while (words_sent < target) begin
      if (words_sent > target - QUIET_TAIL) begin
        allow_gaps   = 1'b0;
        allow_stalls = 1'b0;
      end else begin
        allow_gaps   = $urandom_range(0, 3) != 0;
        allow_stalls = $urandom_range(0, 3) != 0;
      end
      mode = $urandom_range(0, 99) < 65;
      settle_and_set_mode(mode);
      blocks = $urandom_range(1, 5);
      for (int k = 0; k < blocks; k++) begin
        if (mode) begin
          if ($urandom_range(0, 9) == 0) len = $urandom_range(FULL_BLOCK - 2, FULL_BLOCK + 3);
          else len = $urandom_range(1, 12);
          close = (k != blocks - 1) || ($urandom_range(0, 3) != 0);
          send_decode_block(len, close);
        end else begin
          send_encode_block($urandom_range(1, 8));
        end
      end
    end

    // Drain: wait for every due result, then a few more cycles for strays.
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("tb summary: %0d input transactions in both modes, %0d results checked",
             words_sent, results_checked);
    $display("tb summary: status codes seen (bit per code, ok..uncorrectable) %b",
             status_mask);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
